// File: src/headset_jack_and_hook_key_detector_top_assert.svh
// Assertion macros shared by the headset jack detector RTL.
// Each macro checks one implication on the rising edge of clock, disabled during reset.
`ifndef HEADSET_JACK_AND_HOOK_KEY_DETECTOR_TOP_ASSERT_SVH
`define HEADSET_JACK_AND_HOOK_KEY_DETECTOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HJD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hjd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HJD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hjd assertion failed");

`endif

// File: src/hjd_pkg.sv
// Package for the headset jack and hook key detector.
// Holds the counter width, configuration and result types, and register indexes.
package hjd_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CSR_DATA_BITS-1:0] delay_type;

   localparam logic [32:0] COUNT_MAX_WIDE = (33'd1 << COUNT_BITS) - 33'd1;
   localparam count_type COUNT_MAX = COUNT_BITS'(COUNT_MAX_WIDE);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DETECT_ACTIVE_LOW = 3'd0,
      CSR_BUTTON_ACTIVE_LOW = 3'd1,
      CSR_ENABLE_DELAY      = 3'd2,
      CSR_CONFIRM_DELAY     = 3'd3,
      CSR_SHORT_LIMIT       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic      detect_active_low;
      logic      button_active_low;
      delay_type enable_delay;
      delay_type confirm_delay;
      delay_type short_limit;
   } cfg_type;

   typedef struct packed {
      logic jack_present;
      logic key_down;
      logic jack_changed;
      logic key_changed;
      logic button_armed;
   } result_type;

   // Clamps a programmed delay to the largest value a counter can hold.
   function automatic count_type fit_count(delay_type value);
      logic [32:0] wide;
      wide = 33'(value);
      if (wide > COUNT_MAX_WIDE) begin
         return COUNT_MAX;
      end
      return COUNT_BITS'(wide);
   endfunction

endpackage

// File: src/headset_jack_and_hook_key_detector_top.sv
// Top level of the headset jack and hook key detector.
// Depends on hjd_pkg, hjd_csr and hjd_core.
//
//   Port group  Direction  Handshake            Payload
//   req_        in         req_valid/req_stall  detect_level, button_level
//   rsp_        out        rsp_valid/rsp_stall  jack_present, key_down, jack_changed,
//                                               key_changed, button_armed
//   csr_        in         csr_write_en         csr_index, csr_wdata
//
// One transaction per clock is sustained while the result is not stalled; each passes
// through the input register and then the result register.
// Reset is synchronous; it clears the valid flags and core state at once, with no clearing pass.
// A stalled result holds the input register, and the input channel stalls only while
// both registers are full and the result is stalled.
module headset_jack_and_hook_key_detector_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_detect_level,
   input  logic                               req_button_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_jack_present,
   output logic                               rsp_key_down,
   output logic                               rsp_jack_changed,
   output logic                               rsp_key_changed,
   output logic                               rsp_button_armed,
   input  logic                               csr_write_en,
   input  logic [hjd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hjd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   hjd_pkg::cfg_type     cfg;
   hjd_pkg::result_type  result;
   hjd_pkg::result_type  rsp_data_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 in_detect_ff;
   logic                 in_button_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_ready;
   logic                 advance;
   logic                 req_take;

   hjd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   hjd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .detect_level (in_detect_ff),
      .button_level (in_button_ff),
      .cfg          (cfg),
      .result       (result)
   );

   always_comb begin
      out_ready    = !rsp_valid_ff || !rsp_stall;
      advance      = in_valid_ff && out_ready;
      req_stall    = in_valid_ff && !out_ready;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         in_detect_ff <= req_detect_level;
         in_button_ff <= req_button_level;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_jack_present = rsp_data_ff.jack_present;
   assign rsp_key_down     = rsp_data_ff.key_down;
   assign rsp_jack_changed = rsp_data_ff.jack_changed;
   assign rsp_key_changed  = rsp_data_ff.key_changed;
   assign rsp_button_armed = rsp_data_ff.button_armed;

endmodule

// File: src/hjd_csr.sv
// Configuration registers of the headset jack detector.
// Depends on hjd_pkg for the register indexes and the configuration struct.
module hjd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [hjd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hjd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output hjd_pkg::cfg_type                  cfg
);

   hjd_pkg::cfg_type cfg_ff;
   hjd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            hjd_pkg::CSR_DETECT_ACTIVE_LOW: cfg_in.detect_active_low = csr_wdata[0];
            hjd_pkg::CSR_BUTTON_ACTIVE_LOW: cfg_in.button_active_low = csr_wdata[0];
            hjd_pkg::CSR_ENABLE_DELAY:      cfg_in.enable_delay = csr_wdata;
            hjd_pkg::CSR_CONFIRM_DELAY:     cfg_in.confirm_delay = csr_wdata;
            hjd_pkg::CSR_SHORT_LIMIT:       cfg_in.short_limit = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_active_low <= 1'b0;
         cfg_ff.button_active_low <= 1'b0;
         cfg_ff.enable_delay      <= 16'd100;
         cfg_ff.confirm_delay     <= 16'd120;
         cfg_ff.short_limit       <= 16'd24;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/hjd_core.sv
// Tick state of the headset jack detector: jack edges, arming, press and release timers.
// Depends on hjd_pkg and the assertion macro header.
`include "headset_jack_and_hook_key_detector_top_assert.svh"

module hjd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 detect_level,
   input  logic                 button_level,
   input  hjd_pkg::cfg_type     cfg,
   output hjd_pkg::result_type  result
);

   logic                last_detect_ff, last_detect_in;
   logic                last_button_ff, last_button_in;
   logic                jack_reported_ff, jack_reported_in;
   logic                armed_ff, armed_in;
   logic                arm_pending_ff, arm_pending_in;
   logic                press_pending_ff, press_pending_in;
   logic                release_pending_ff, release_pending_in;
   logic                key_reported_ff, key_reported_in;
   hjd_pkg::count_type  arm_count_ff, arm_count_in;
   hjd_pkg::count_type  press_count_ff, press_count_in;
   hjd_pkg::count_type  release_count_ff, release_count_in;
   hjd_pkg::count_type  press_age_ff, press_age_in;
   logic                detect;
   logic                button;

   always_comb begin
      detect = detect_level ^ cfg.detect_active_low;
      button = button_level ^ cfg.button_active_low;

      jack_reported_in   = jack_reported_ff;
      armed_in           = armed_ff;
      arm_pending_in     = arm_pending_ff;
      press_pending_in   = press_pending_ff;
      release_pending_in = release_pending_ff;
      key_reported_in    = key_reported_ff;

      press_age_in = press_age_ff;
      if (press_age_ff != hjd_pkg::COUNT_MAX) begin
         press_age_in = press_age_ff + 1'b1;
      end
      arm_count_in = arm_count_ff;
      if (arm_pending_ff && arm_count_ff != '0) begin
         arm_count_in = arm_count_ff - 1'b1;
      end
      press_count_in = press_count_ff;
      if (press_pending_ff && press_count_ff != '0) begin
         press_count_in = press_count_ff - 1'b1;
      end
      release_count_in = release_count_ff;
      if (release_pending_ff && release_count_ff != '0) begin
         release_count_in = release_count_ff - 1'b1;
      end

      if (detect != last_detect_ff) begin
         if (detect) begin
            if (!armed_ff) begin
               jack_reported_in = 1'b1;
               arm_pending_in   = 1'b1;
               arm_count_in     = hjd_pkg::fit_count(cfg.enable_delay);
            end
         end else begin
            key_reported_in    = 1'b0;
            press_pending_in   = 1'b0;
            press_count_in     = '0;
            release_pending_in = 1'b0;
            release_count_in   = '0;
            jack_reported_in   = 1'b0;
            armed_in           = 1'b0;
            arm_pending_in     = 1'b0;
            arm_count_in       = '0;
         end
      end

      if (arm_pending_in && arm_count_in == '0) begin
         arm_pending_in = 1'b0;
         armed_in       = 1'b1;
      end

      if (button != last_button_ff && armed_in) begin
         if (button) begin
            press_age_in = '0;
            if (!press_pending_in) begin
               press_pending_in = 1'b1;
               press_count_in   = hjd_pkg::fit_count(cfg.confirm_delay);
            end
         end else if (press_age_in < hjd_pkg::fit_count(cfg.short_limit)) begin
            press_pending_in = 1'b0;
            press_count_in   = '0;
         end else if (!release_pending_in) begin
            release_pending_in = 1'b1;
            release_count_in   = hjd_pkg::fit_count(cfg.confirm_delay);
         end
      end

      if (press_pending_in && press_count_in == '0) begin
         press_pending_in = 1'b0;
         key_reported_in  = 1'b1;
      end
      if (release_pending_in && release_count_in == '0) begin
         release_pending_in = 1'b0;
         key_reported_in    = 1'b0;
      end

      last_detect_in = detect;
      last_button_in = button;

      result.jack_present = jack_reported_in;
      result.key_down     = key_reported_in;
      result.jack_changed = jack_reported_in != jack_reported_ff;
      result.key_changed  = key_reported_in != key_reported_ff;
      result.button_armed = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_detect_ff     <= 1'b0;
         last_button_ff     <= 1'b0;
         jack_reported_ff   <= 1'b0;
         armed_ff           <= 1'b0;
         arm_pending_ff     <= 1'b0;
         press_pending_ff   <= 1'b0;
         release_pending_ff <= 1'b0;
         key_reported_ff    <= 1'b0;
         arm_count_ff       <= '0;
         press_count_ff     <= '0;
         release_count_ff   <= '0;
         press_age_ff       <= '0;
      end else if (step) begin
         last_detect_ff     <= last_detect_in;
         last_button_ff     <= last_button_in;
         jack_reported_ff   <= jack_reported_in;
         armed_ff           <= armed_in;
         arm_pending_ff     <= arm_pending_in;
         press_pending_ff   <= press_pending_in;
         release_pending_ff <= release_pending_in;
         key_reported_ff    <= key_reported_in;
         arm_count_ff       <= arm_count_in;
         press_count_ff     <= press_count_in;
         release_count_ff   <= release_count_in;
         press_age_ff       <= press_age_in;
      end
   end

   // The button can only be armed, and the key only reported down, while the jack is in.
   `HJD_ASSERT_SAME(armed_needs_jack, armed_ff || arm_pending_ff, jack_reported_ff)
   `HJD_ASSERT_SAME(key_needs_jack, key_reported_ff, jack_reported_ff)
   `HJD_ASSERT_SAME(pending_needs_armed, press_pending_ff || release_pending_ff, armed_ff)
   `HJD_ASSERT_NEXT(idle_holds_key, !step, $stable(key_reported_ff) && $stable(armed_ff))

endmodule
